// File: rtl/spc_pkg.sv
// Shared types and constants for the simplex projection column block.
`default_nettype none
package spc_pkg;
  typedef enum logic [3:0] {
    ST_LOAD, ST_SORT_RD, ST_SORT_CMP, ST_SORT_WR,
    ST_SCAN_RD, ST_SCAN_DIV, ST_SCAN_CHK,
    ST_THETA, ST_THETA_DIV, ST_OUT_RD, ST_OUT_WAIT, ST_OUT_HOLD
  } spc_state_t;

  localparam int unsigned DivW = 40;
  localparam int unsigned DenW = 7;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } spc_div_ctl_t;
endpackage
`default_nettype wire

// File: rtl/spc_divider.sv
// Iterative signed divider, truncating toward zero, one quotient bit per cycle.
`default_nettype none
module spc_divider
  import spc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic signed [DivW-1:0] dividend,
  input  wire logic [DenW-1:0]        divisor,
  output spc_div_ctl_t                ctl,
  output logic signed [DivW-1:0]      quotient
);
  logic [DivW-1:0] rem_q;
  logic [DivW-1:0] quo;
  logic [DenW-1:0] den;
  logic            neg;
  logic [5:0]      cnt;
  logic            busy;
  logic            done;
  logic [DivW:0]   trial;

  assign trial = {rem_q, quo[DivW-1]} - {{(DivW+1-DenW){1'b0}}, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= 6'(DivW);
        neg   <= dividend[DivW-1];
        quo   <= dividend[DivW-1] ? DivW'(-dividend) : dividend;
        rem_q <= '0;
        den   <= divisor;
      end else if (busy) begin
        if (!trial[DivW]) begin
          rem_q <= trial[DivW-1:0];
          quo   <= {quo[DivW-2:0], 1'b1};
        end else begin
          rem_q <= {rem_q[DivW-2:0], quo[DivW-1]};
          quo   <= {quo[DivW-2:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg ? -$signed(quo) : $signed(quo);
  assign ctl = '{start: start, busy: busy, done: done};
endmodule
`default_nettype wire

// File: rtl/simplex_projection_column.sv
// Simplex projection of one column: load, insertion sort, threshold scan, emit.
// Loading: one element per cycle. At vector end the block stalls its input while it
// sorts (insertion sort over one memory port), scans (one division per prefix step
// on the shared divider), divides once for theta (both skipped for a zero radius)
// and emits the results one by one. Reset (synchronous) clears count and state.
`default_nettype none
module simplex_projection_column
  import spc_pkg::*;
#(
  parameter int COLUMN_LEN = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] element_value,
  input  wire logic [30:0] radius,
  input  wire logic        last_element,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [30:0]      projected_value,
  output logic             last_result
);
  localparam int AW = (COLUMN_LEN > 1) ? $clog2(COLUMN_LEN) : 1;
  localparam int CW = AW + 1;

  logic signed [31:0] orig_mem [COLUMN_LEN];
  logic signed [31:0] sort_mem [COLUMN_LEN];

  spc_state_t state, state_next;
  logic [CW-1:0] load_count, n, i, j;
  logic [30:0] radius_hold;
  logic signed [31:0] key, rd_sort, rd_orig;
  logic [AW-1:0] sort_addr, orig_addr;
  logic sort_we;
  logic signed [31:0] sort_wd;
  logic signed [DivW-1:0] sum, theta;
  logic signed [DivW-1:0] div_num;
  logic [DenW-1:0] div_den;
  logic div_start;
  spc_div_ctl_t div_ctl;
  logic signed [DivW-1:0] div_q;
  logic [CW-1:0] k;
  logic signed [31:0] cur;
  logic signed [DivW:0] diff;
  logic accept_in, ends;

  assign accept_in = in_valid && !in_stall;
  assign in_stall  = (state != ST_LOAD);
  assign ends = last_element || (load_count + CW'(1) >= CW'(COLUMN_LEN));

  always_ff @(posedge clk) begin
    if (accept_in) orig_mem[load_count[AW-1:0]] <= element_value;
    rd_orig <= orig_mem[orig_addr];
  end
  always_ff @(posedge clk) begin
    if (sort_we) sort_mem[sort_addr] <= sort_wd;
    rd_sort <= sort_mem[sort_addr];
  end

  spc_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_num),
    .divisor(div_den), .ctl(div_ctl), .quotient(div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= ST_LOAD;
    else     state <= state_next;
  end

  // sort: i walks up; key bubbles down via j. sort entries [0,i) are sorted.
  always_comb begin
    state_next = state;
    sort_we = 1'b0;
    sort_wd = key;
    sort_addr = '0;
    orig_addr = i[AW-1:0];
    div_start = 1'b0;
    div_num = sum - DivW'(signed'({1'b0, radius_hold}));
    div_den = DenW'(k);
    case (state)
      ST_LOAD: if (accept_in && ends) state_next = ST_SORT_RD;
      ST_SORT_RD: begin
        orig_addr = i[AW-1:0];
        if (i == n) state_next = (radius_hold == '0) ? ST_OUT_RD : ST_SCAN_RD;
        else state_next = ST_SORT_CMP;
      end
      ST_SORT_CMP: begin
        sort_addr = AW'(j - CW'(1));
        state_next = ST_SORT_WR;
      end
      ST_SORT_WR: begin
        if (j != '0 && rd_sort < key) begin
          sort_addr = j[AW-1:0]; sort_wd = rd_sort; sort_we = 1'b1;
          state_next = ST_SORT_CMP;
        end else begin
          sort_addr = j[AW-1:0]; sort_wd = key; sort_we = 1'b1;
          state_next = ST_SORT_RD;
        end
      end
      ST_SCAN_RD: begin
        sort_addr = AW'(k - CW'(1));
        state_next = ST_SCAN_DIV;
      end
      ST_SCAN_DIV: begin
        sort_addr = AW'(k - CW'(1));
        // the fetched element joins the sum for this step's division
        div_num = sum + DivW'(signed'(rd_sort)) - DivW'(signed'({1'b0, radius_hold}));
        div_start = 1'b1;
        state_next = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        sort_addr = AW'(k - CW'(1));
        if (div_ctl.done) begin
          if ((DivW'(signed'(cur)) - div_q) > 0 && k < n) state_next = ST_SCAN_RD;
          else state_next = ST_THETA;
        end
      end
      ST_THETA: begin
        div_start = 1'b1;
        state_next = ST_THETA_DIV;
      end
      ST_THETA_DIV: if (div_ctl.done) state_next = ST_OUT_RD;
      ST_OUT_RD: begin
        orig_addr = i[AW-1:0];
        state_next = ST_OUT_WAIT;
      end
      ST_OUT_WAIT: state_next = ST_OUT_HOLD;
      ST_OUT_HOLD: if (!out_stall) state_next = last_result ? ST_LOAD : ST_OUT_RD;
      default: state_next = ST_LOAD;
    endcase
  end

  assign diff = (DivW+1)'(signed'(rd_orig)) - (DivW+1)'(theta);

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      radius_hold <= '0;
      out_valid <= 1'b0;
      i <= '0;
      j <= '0;
      k <= '0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (accept_in) begin
            if (ends) begin
              n <= load_count + CW'(1);
              load_count <= '0;
              radius_hold <= radius;
              i <= '0;
            end else begin
              load_count <= load_count + CW'(1);
            end
          end
        end
        ST_SORT_RD: begin
          j <= i;
          if (i == n) begin
            i <= '0;
            k <= CW'(1);
            sum <= '0;
            theta <= '0;
          end
        end
        ST_SORT_CMP: if (j == i) key <= rd_orig;
        ST_SORT_WR: begin
          if (j != '0 && rd_sort < key) j <= j - CW'(1);
          else i <= i + CW'(1);
        end
        ST_SCAN_DIV: begin
          cur <= rd_sort;
        end
        ST_SCAN_RD: ;
        ST_SCAN_CHK: begin
          if (div_ctl.done) begin
            if ((DivW'(signed'(cur)) - div_q) > 0 && k < n) k <= k + CW'(1);
            else begin
              if ((DivW'(signed'(cur)) - div_q) <= 0) begin
                sum <= sum - DivW'(signed'(cur));
                k <= k - CW'(1);
              end
            end
          end
        end
        ST_THETA_DIV: if (div_ctl.done) theta <= (k == '0) ? '0 : div_q;
        ST_OUT_WAIT: begin
          out_valid <= 1'b1;
          last_result <= (i + CW'(1) == n);
          if (radius_hold == '0 || diff < 0) projected_value <= '0;
          else if (diff > (DivW+1)'(32'h7FFFFFFF)) projected_value <= 31'h7FFFFFFF;
          else projected_value <= diff[30:0];
        end
        ST_OUT_HOLD: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            i <= i + CW'(1);
          end
        end
        default: ;
      endcase
      // sum grows when a new sorted element is fetched in the scan
      if (state == ST_SCAN_DIV) sum <= sum + DivW'(signed'(rd_sort));
    end
  end

  // theta division: k==0 would feed a zero divisor; result is discarded then
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while emitting");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(projected_value)))
    else $error("result changed while stalled");
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_ctl.busy) else $error("divider restarted while busy");
endmodule
`default_nettype wire

// File: dv/tb.sv
// Testbench for simplex_projection_column: queued driver, monitor, vector projection predictor.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VecMax = 64;
  localparam longint OutMax = 64'sd2147483647;

  typedef struct {
    logic [31:0] value;
    logic [30:0] rad;
    logic        last;
  } elem_t;

  typedef struct {
    logic [30:0] proj;
    logic        last;
  } proj_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] element_value;
  logic [30:0] radius;
  logic        last_element;
  logic        out_valid;
  logic        out_stall;
  logic [30:0] projected_value;
  logic        last_result;

  elem_t pending_elems[$];
  proj_t expected_projs[$];
  int    errors;
  longint cycle_count;

  // predictor state
  int              held_count;
  logic signed [31:0] held_vals[VecMax];

  simplex_projection_column #(.COLUMN_LEN(VecMax)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .element_value(element_value), .radius(radius), .last_element(last_element),
    .out_valid(out_valid), .out_stall(out_stall),
    .projected_value(projected_value), .last_result(last_result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint theta_of(int n, longint r);
    longint srt[VecMax];
    longint key, acc;
    int j, k;
    for (int i = 0; i < n; i++) srt[i] = held_vals[i];
    for (int i = 1; i < n; i++) begin
      key = srt[i];
      j = i;
      while (j > 0 && srt[j-1] < key) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = key;
    end
    k = 1;
    acc = srt[0];
    while (srt[k-1] - (acc - r) / k > 0 && k <= n - 1) begin
      k++;
      acc += srt[k-1];
    end
    if (srt[k-1] - (acc - r) / k <= 0) begin
      acc -= srt[k-1];
      k--;
    end
    if (k <= 0) return 0;
    return (acc - r) / k;
  endfunction

  task automatic project_elem(elem_t e);
    proj_t p;
    longint theta, d;
    held_vals[held_count] = $signed(e.value);
    held_count++;
    if (!(e.last || held_count >= VecMax)) return;
    theta = (e.rad != 0) ? theta_of(held_count, longint'(e.rad)) : 0;
    for (int i = 0; i < held_count; i++) begin
      d = 0;
      if (e.rad != 0) begin
        d = longint'(held_vals[i]) - theta;
        if (d < 0) d = 0;
        if (d > OutMax) d = OutMax;
      end
      p.proj = d[30:0];
      p.last = (i == held_count - 1);
      expected_projs.push_back(p);
    end
    held_count = 0;
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h8000_0000 | $urandom_range(0, 3);
      2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      default: return 32'($signed($urandom_range(0, 2 ** 20)) - 2 ** 19);
    endcase
  endfunction

  function automatic logic [30:0] rand_radius();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 31'h7FFF_FFFF;
      2: return 31'($urandom());
      default: return 31'($urandom_range(1, 2 ** 21));
    endcase
  endfunction

  task automatic add_vector(int len, logic [30:0] r);
    elem_t e;
    for (int i = 0; i < len; i++) begin
      e.value = rand_value();
      e.rad = 31'($urandom());
      e.last = (i == len - 1);
      if (e.last) e.rad = r;
      pending_elems.push_back(e);
    end
  endtask

  // driver
  int gap_left, burst_left;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
      burst_left <= 0;
    end else if (in_valid && in_stall) begin
      // hold stalled item
    end else begin
      if (in_valid) begin
        project_elem('{element_value, radius, last_element});
      end
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_elems.size() > 0) begin
        elem_t e;
        e = pending_elems.pop_front();
        in_valid <= 1'b1;
        element_value <= e.value;
        radius <= e.rad;
        last_element <= e.last;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 20);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern, with one long hold-off
  int stall_mode, hold_left;
  bit long_hold_done;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_mode <= 0;
      hold_left <= 0;
      long_hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= (hold_left > 1);
    end else if (!long_hold_done && cycle_count > 3000) begin
      long_hold_done <= 1'b1;
      hold_left <= 3000;
      out_stall <= 1'b1;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_projs.size() == 0) begin
        $display("%0t: unexpected result proj=%h last=%b", $time,
                 projected_value, last_result);
        errors++;
      end else begin
        proj_t p;
        p = expected_projs.pop_front();
        if (p.proj !== projected_value) begin
          $display("%0t: projected_value expected %h actual %h", $time,
                   p.proj, projected_value);
          errors++;
        end
        if (p.last !== last_result) begin
          $display("%0t: last_result expected %b actual %b", $time,
                   p.last, last_result);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3_000_000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    cycle_count = 0;
    errors = 0;
    held_count = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    out_stall = 1'b0;
    element_value = '0;
    radius = '0;
    last_element = 1'b0;
    // directed vectors
    pending_elems.push_back('{32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1});
    pending_elems.push_back('{32'h8000_0000, 31'h7FFF_FFFF, 1'b1});
    pending_elems.push_back('{32'h0001_0000, 31'h7FFF_FFFF, 1'b0});
    pending_elems.push_back('{32'h8000_0000, 31'h0000_0000, 1'b0});
    pending_elems.push_back('{32'h0002_0000, 31'h0001_0000, 1'b1});
    pending_elems.push_back('{32'h0003_0000, 31'h0, 1'b0});
    pending_elems.push_back('{32'hFFFF_0000, 31'h0, 1'b1});
    pending_elems.push_back('{32'h7FFF_FFFF, 31'h1, 1'b0});
    pending_elems.push_back('{32'h8000_0000, 31'h1, 1'b1});
    add_vector(4, 31'h0002_8000);
    add_vector(VecMax, 31'h0010_0000);
    // this vector ends by count: last_element stays low throughout
    for (int i = 0; i < VecMax; i++)
      pending_elems.push_back('{rand_value(), rand_radius(), 1'b0});
    // random vectors, mostly short
    for (int n = 0; n < 90; ) begin
      int len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, VecMax) : $urandom_range(1, 8);
      add_vector(len, rand_radius());
      n += len;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    while (pending_elems.size() != 0) @(posedge clk);
    @(posedge clk);
    while (in_valid) @(posedge clk);
    while (expected_projs.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_projs.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
